/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold on the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bsfr_pkg.sv */
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver package
// Result kinds, register indexes, reset values and the queue entry type.
// ----------------------------------------------------------------------------
package bsfr_pkg;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FLAG_BYTE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESTART_BYTE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MASK   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 3'd4;

	localparam logic [7:0]  RST_FLAG_BYTE     = 8'd126;
	localparam logic [7:0]  RST_ESCAPE_BYTE   = 8'd125;
	localparam logic [7:0]  RST_RESTART_BYTE  = 8'd127;
	localparam logic [7:0]  RST_ESCAPE_MASK   = 8'd32;
	localparam logic [15:0] RST_MAX_FRAME_LEN = 16'd256;

	// One queue entry holds every result caused by one input byte. When pair
	// is set, a frame-complete result carrying len follows the first one.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] idx;
		logic [15:0] len;
		logic        pair;
	} entry_t;

endpackage

/* rtl/bsfr_if.sv */
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver channels
// Valid/ready channels for raw link bytes and for receiver results.
// ----------------------------------------------------------------------------
interface bsfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface bsfr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;
	logic [15:0] frame_length;
	logic        last;

	modport source (output valid, output kind, output data_byte, output byte_index,
		output frame_length, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input byte_index,
		input frame_length, input last, output ready);
endinterface

/* rtl/byte_stuffed_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver core
// Removes byte stuffing from a link byte stream and reports payload bytes,
// frame completions and frame restarts.
// ----------------------------------------------------------------------------
// The receiver takes one raw link byte per beat on the link channel and
// accepts a new byte in every cycle while its two-entry result queue has a
// free slot. Each byte is decoded in the cycle it is accepted: the framing
// state (in-frame flag, escape flag, byte count) is updated at that edge and
// the results the byte causes are written into the queue as one entry, so a
// result appears on the result channel from the registered queue. Most bytes
// cause one result or none, which sustains one byte per cycle while results
// are taken; a byte that fills a frame to max_frame_len causes a data
// result and a frame-complete result, and that entry takes two result beats
// to drain. The queue lets the link side run on while results stall. Bytes are
// ignored until the flag byte arrives; the flag byte has priority over the
// restart byte, which has priority over the escape byte when registers hold
// equal values. A flag byte after at least one payload byte closes the frame
// and keeps the receiver in frame; reaching max_frame_len closes the frame
// and returns to hunting. Registers are written through
// cfg_we/cfg_index/cfg_data and should only be changed while the receiver is
// idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_stuffed_frame_receiver_core
	import bsfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bsfr_in_if.sink               link,
	bsfr_out_if.source            result
);

	// Configuration registers.
	logic [7:0]  flag_byte_q;
	logic [7:0]  escape_byte_q;
	logic [7:0]  restart_byte_q;
	logic [7:0]  escape_mask_q;
	logic [15:0] max_frame_len_q;

	// Framing state.
	logic        in_frame_q;
	logic        escape_q;
	logic [15:0] count_q;

	// Result queue: two entries, each holding the results of one byte.
	entry_t      mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        sub_q;   // set while the second result of a pair is shown

	// Decode of the byte on the link channel.
	logic        accept;
	logic        hit_start;
	logic        hit_restart;
	logic        hit_escape;
	logic [7:0]  payload;
	logic [15:0] count_inc;
	logic        in_frame_d;
	logic        escape_d;
	logic [15:0] count_d;
	logic        wr_en;
	entry_t      wr_entry;

	// Result side.
	entry_t      head;
	logic        beat_out;
	logic        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_byte_q     <= RST_FLAG_BYTE;
			escape_byte_q   <= RST_ESCAPE_BYTE;
			restart_byte_q  <= RST_RESTART_BYTE;
			escape_mask_q   <= RST_ESCAPE_MASK;
			max_frame_len_q <= RST_MAX_FRAME_LEN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FLAG_BYTE:     flag_byte_q     <= cfg_data[7:0];
				REG_ESCAPE_BYTE:   escape_byte_q   <= cfg_data[7:0];
				REG_RESTART_BYTE:  restart_byte_q  <= cfg_data[7:0];
				REG_ESCAPE_MASK:   escape_mask_q   <= cfg_data[7:0];
				REG_MAX_FRAME_LEN: max_frame_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign link.ready = (fill_q != 2'd2);
	assign accept     = link.valid && link.ready;

	assign hit_start   = (link.byte_in == flag_byte_q);
	assign hit_restart = (link.byte_in == restart_byte_q);
	assign hit_escape  = (link.byte_in == escape_byte_q);
	assign payload     = escape_q ? (link.byte_in ^ escape_mask_q) : link.byte_in;
	assign count_inc   = count_q + 16'd1;

	// Next framing state and the queue entry for the byte on the link.
	always_comb begin
		in_frame_d = in_frame_q;
		escape_d   = escape_q;
		count_d    = count_q;
		wr_en      = 1'b0;
		wr_entry   = '{kind: KIND_DATA, data: 8'd0, idx: 16'd0, len: 16'd0, pair: 1'b0};
		priority if (hit_start) begin
			if (!in_frame_q) begin
				in_frame_d = 1'b1;
			end else if (count_q != 16'd0) begin
				// Delimiter closes a non-empty frame; the receiver stays started.
				wr_en         = 1'b1;
				wr_entry.kind = KIND_DONE;
				wr_entry.len  = count_q;
				count_d       = 16'd0;
				escape_d      = 1'b0;
			end
		end else if (!in_frame_q) begin
			// Hunting: everything but the start delimiter is dropped.
		end else if (hit_restart) begin
			wr_en         = 1'b1;
			wr_entry.kind = KIND_RESTART;
			count_d       = 16'd0;
		end else if (hit_escape) begin
			escape_d = 1'b1;
		end else begin
			wr_en         = 1'b1;
			wr_entry.kind = KIND_DATA;
			wr_entry.data = payload;
			wr_entry.idx  = count_q;
			escape_d      = 1'b0;
			if (count_inc >= max_frame_len_q) begin
				// Length limit: a frame-complete result follows, back to hunting.
				wr_entry.len  = count_inc;
				wr_entry.pair = 1'b1;
				in_frame_d    = 1'b0;
				escape_d      = 1'b0;
				count_d       = 16'd0;
			end else begin
				count_d = count_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			escape_q   <= 1'b0;
			count_q    <= 16'd0;
		end else if (accept) begin
			in_frame_q <= in_frame_d;
			escape_q   <= escape_d;
			count_q    <= count_d;
		end
	end

	// Queue storage carries payload only; it needs no reset.
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	assign head     = mem_q[rd_ptr_q];
	assign beat_out = result.valid && result.ready;
	assign pop      = beat_out && (sub_q || !head.pair);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
			sub_q    <= 1'b0;
		end else begin
			if (accept && wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
				sub_q    <= 1'b0;
			end else if (beat_out) begin
				sub_q <= 1'b1;
			end
			unique case ({accept && wr_en, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	// The first result of an entry is its stored kind; the second of a pair
	// is always the frame-complete notice with the stored length.
	assign result.valid        = (fill_q != 2'd0);
	assign result.kind         = sub_q ? KIND_DONE : head.kind;
	assign result.data_byte    = sub_q ? 8'd0 : head.data;
	assign result.byte_index   = sub_q ? 16'd0 : head.idx;
	assign result.frame_length = (sub_q || head.kind == KIND_DONE) ? head.len : 16'd0;
	assign result.last         = sub_q || !head.pair;

	// Assertions.
	`ASSERT_ALWAYS(a_fill_bound, fill_q != 2'd3, "result queue fill count out of range")
	`ASSERT_IMPLIES(a_sub_pair, sub_q, (fill_q != 2'd0) && head.pair, "tail beat without a pair")
	`ASSERT_ALWAYS(a_escape_framed, in_frame_q || !escape_q, "escape pending while hunting")
	`ASSERT_NEXT(a_full_stall, (fill_q == 2'd2) && !pop, !link.ready, "byte taken into full queue")

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver testbench
// Drives raw link bytes into the receiver, predicts the unstuffed payload,
// frame-complete and restart results, and checks every result beat in order.
// ----------------------------------------------------------------------------
// The run is split into phases. The first runs at reset settings; each later
// phase programs the five registers while the receiver is idle. Every phase
// streams a mix of well-formed stuffed frames, broken frames and line noise.
// A clocked driver feeds link beats from a queue of pending bytes and runs
// the deframing prediction on each accepted beat. A clocked monitor compares
// each accepted result beat against the oldest predicted result. Back-pressure
// and source gaps are randomized, with a schedule changed at some phases.
// ----------------------------------------------------------------------------
module tb;
	import bsfr_pkg::*;

	// One predicted result beat.
	typedef struct {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] idx;
		logic [15:0] len;
		logic        last;
	} rx_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bsfr_in_if  link ();
	bsfr_out_if result ();

	byte_stuffed_frame_receiver_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.link      (link),
		.result    (result)
	);

	// Register copies used by both the stimulus and the prediction.
	logic [7:0]  start_val;
	logic [7:0]  escape_val;
	logic [7:0]  restart_val;
	logic [7:0]  mask_val;
	logic [15:0] max_len_val;

	// Predicted framing state.
	logic        rx_in_frame;
	logic        rx_escape;
	logic [15:0] rx_count;

	logic [7:0]  pending_bytes[$];
	rx_result_t  expected_results[$];

	int unsigned bytes_queued;
	int unsigned bytes_accepted;
	int unsigned mismatches;
	int unsigned result_beats;
	int unsigned data_beats;
	int unsigned frames_closed;
	int unsigned restarts;
	int unsigned settings_used;
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;

	always #5 clk = ~clk;

	// A generous ceiling on the whole run.
	initial begin
		#5_000_000;
		$display("Timeout with %0d results still expected", expected_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic void add_result(input kind_t kind, input logic [7:0] data,
		input logic [15:0] idx, input logic [15:0] len, input logic last);
		rx_result_t r;
		r.kind = kind;
		r.data = data;
		r.idx  = idx;
		r.len  = len;
		r.last = last;
		expected_results.push_back(r);
	endfunction

	// Deframing prediction for one accepted link byte. The start delimiter is
	// tested first, then the restart byte, then the escape byte.
	function automatic void deframe_byte(input logic [7:0] raw);
		logic [7:0]  payload;
		logic [15:0] pos;
		payload = raw;
		if (raw == start_val) begin
			if (!rx_in_frame) begin
				rx_in_frame = 1'b1;
			end else if (rx_count != 16'd0) begin
				add_result(KIND_DONE, 8'd0, 16'd0, rx_count, 1'b1);
				rx_count  = 16'd0;
				rx_escape = 1'b0;
			end
			return;
		end
		if (!rx_in_frame)
			return;
		if (raw == restart_val) begin
			rx_count = 16'd0;
			add_result(KIND_RESTART, 8'd0, 16'd0, 16'd0, 1'b1);
			return;
		end
		if (raw == escape_val) begin
			rx_escape = 1'b1;
			return;
		end
		if (rx_escape) begin
			rx_escape = 1'b0;
			payload   = raw ^ mask_val;
		end
		pos      = rx_count;
		rx_count = rx_count + 16'd1;
		if (rx_count >= max_len_val) begin
			add_result(KIND_DATA, payload, pos, 16'd0, 1'b0);
			add_result(KIND_DONE, 8'd0, 16'd0, rx_count, 1'b1);
			rx_in_frame = 1'b0;
			rx_escape   = 1'b0;
			rx_count    = 16'd0;
		end else begin
			add_result(KIND_DATA, payload, pos, 16'd0, 1'b1);
		end
	endfunction

	// Link driver: a beat is held until accepted, and the next byte is offered
	// in the same edge unless a random gap is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			link.valid   <= 1'b0;
			link.byte_in <= 8'd0;
		end else begin
			if (link.valid && link.ready) begin
				deframe_byte(link.byte_in);
				bytes_accepted++;
			end
			if (!link.valid || link.ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					link.valid   <= 1'b1;
					link.byte_in <= pending_bytes.pop_front();
				end else begin
					link.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: every accepted result beat is checked against the oldest
	// prediction, field by field.
	always @(posedge clk) begin
		rx_result_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				result_beats++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result beat: kind %0d data %02h idx %0d len %0d last %0b",
							result.kind, result.data_byte, result.byte_index,
							result.frame_length, result.last);
				end else begin
					want = expected_results.pop_front();
					case (want.kind)
						KIND_DATA: data_beats++;
						KIND_DONE: frames_closed++;
						default:   restarts++;
					endcase
					if (result.kind !== want.kind || result.data_byte !== want.data ||
						result.byte_index !== want.idx || result.frame_length !== want.len ||
						result.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch at result %0d: expected kind %0d data %02h idx %0d len %0d last %0b",
								result_beats, want.kind, want.data, want.idx, want.len,
								want.last);
							$display("  got kind %0d data %02h idx %0d len %0d last %0b",
								result.kind, result.data_byte, result.byte_index,
								result.frame_length, result.last);
						end
					end
				end
			end
			result.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	// Payload byte with stuffing: a byte that collides with a control value is
	// usually escaped, and sometimes sent raw to exercise the control paths.
	task automatic queue_payload(input logic [7:0] v);
		if ((v == start_val || v == escape_val || v == restart_val) &&
			$urandom_range(3) != 0) begin
			queue_byte(escape_val);
			queue_byte(v ^ mask_val);
		end else begin
			queue_byte(v);
		end
	endtask

	task automatic queue_frame(input int unsigned len);
		int unsigned i;
		logic [7:0]  v;
		if ($urandom_range(1) == 0)
			queue_byte(start_val);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(99) < 3)
				queue_byte(restart_val);
			case ($urandom_range(11))
				0:       v = start_val;
				1:       v = escape_val;
				2:       v = restart_val;
				default: v = 8'($urandom_range(255));
			endcase
			queue_payload(v);
		end
		// A dangling escape before the delimiter is cleared if that delimiter closes a non-empty frame.
		if ($urandom_range(99) < 4)
			queue_byte(escape_val);
		queue_byte(start_val);
	endtask

	// Random traffic for one phase: mostly well-formed frames, some broken
	// frames and some raw noise.
	task automatic queue_traffic(input int unsigned budget);
		int unsigned first;
		int unsigned n;
		int unsigned i;
		int unsigned pick;
		first = bytes_queued;
		while (bytes_queued - first < budget) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				queue_byte(8'($urandom_range(255)));
			end else if (pick < 12) begin
				queue_byte(start_val);
				n = $urandom_range(6);
				for (i = 0; i < n; i++)
					queue_byte(8'($urandom_range(255)));
			end else if (pick < 17 && max_len_val <= 16'd300) begin
				// Lengths around the limit, so the length close is hit.
				queue_frame(int'(max_len_val) - 1 + $urandom_range(2));
			end else begin
				queue_frame($urandom_range(12));
			end
		end
	endtask

	// Waits until every queued byte has been taken and every predicted result
	// has arrived.
	task automatic wait_drained();
		while (bytes_accepted != bytes_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_FLAG_BYTE:     start_val   = val[7:0];
			REG_ESCAPE_BYTE:   escape_val  = val[7:0];
			REG_RESTART_BYTE:  restart_val = val[7:0];
			REG_ESCAPE_MASK:   mask_val    = val[7:0];
			REG_MAX_FRAME_LEN: max_len_val = val;
			default: ;
		endcase
	endtask

	// Programs all five registers. Byte registers get random upper bits, which
	// the receiver must drop.
	task automatic apply_settings(input logic [7:0] s, input logic [7:0] e,
		input logic [7:0] r, input logic [7:0] m, input logic [15:0] len);
		write_reg(REG_FLAG_BYTE, {8'($urandom_range(255)), s});
		write_reg(REG_ESCAPE_BYTE, {8'($urandom_range(255)), e});
		write_reg(REG_RESTART_BYTE, {8'($urandom_range(255)), r});
		write_reg(REG_ESCAPE_MASK, {8'($urandom_range(255)), m});
		write_reg(REG_MAX_FRAME_LEN, len);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	localparam int unsigned PHASE_BUDGET = 235;

	initial begin
		logic [7:0] directed[] = '{8'h00, 8'hFF, 8'h7D, 8'h7E, 8'h7E, 8'h00, 8'hFF,
			8'h7D, 8'h5E, 8'h7D, 8'h7D, 8'h41, 8'h7E, 8'h7D, 8'h7E, 8'h01, 8'h7F,
			8'h02, 8'h7D, 8'h7F, 8'h03, 8'h7E};
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		link.valid   = 1'b0;
		link.byte_in = 8'd0;
		result.ready = 1'b0;
		start_val    = RST_FLAG_BYTE;
		escape_val   = RST_ESCAPE_BYTE;
		restart_val  = RST_RESTART_BYTE;
		mask_val     = RST_ESCAPE_MASK;
		max_len_val  = RST_MAX_FRAME_LEN;
		rx_in_frame  = 1'b0;
		rx_escape    = 1'b0;
		rx_count     = 16'd0;
		bytes_queued   = 0;
		bytes_accepted = 0;
		mismatches     = 0;
		result_beats   = 0;
		data_beats     = 0;
		frames_closed  = 0;
		restarts       = 0;
		settings_used  = 1;
		// Sparse source gaps, heavy back-pressure for the first phases.
		src_idle_pct = 7;
		snk_idle_pct = 85;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opener at reset settings: ignored bytes while hunting, an
		// empty frame, the byte extremes, an escaped delimiter, a double
		// escape, an escape that survives an empty frame, restarts with and
		// without a pending escape, and a delimiter closing a frame.
		foreach (directed[i])
			queue_byte(directed[i]);
		queue_traffic(PHASE_BUDGET);
		wait_drained();

		// Extreme register values with a one-byte frame limit.
		apply_settings(8'h00, 8'hFF, 8'h80, 8'hFF, 16'd1);
		queue_traffic(PHASE_BUDGET);
		wait_drained();

		// Source is now the slow side.
		src_idle_pct = 85;
		snk_idle_pct = 7;
		apply_settings(8'hFF, 8'h00, 8'h01, 8'h01, 16'd65535);
		queue_traffic(PHASE_BUDGET);
		wait_drained();

		// Restart and escape share a value, so restart must win.
		apply_settings(8'h10, 8'h20, 8'h20, 8'h80, 16'd4);
		queue_traffic(PHASE_BUDGET);
		wait_drained();

		// Full rate on both sides from here on.
		src_idle_pct = 0;
		snk_idle_pct = 0;
		// Start and restart share a value, so the delimiter must win.
		apply_settings(8'h7E, 8'h7D, 8'h7E, 8'h00, 16'd2);
		queue_traffic(PHASE_BUDGET);
		wait_drained();

		apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 16'($urandom_range(1, 40)));
		queue_traffic(PHASE_BUDGET);
		wait_drained();

		apply_settings(RST_FLAG_BYTE, RST_ESCAPE_BYTE, RST_RESTART_BYTE, RST_ESCAPE_MASK,
			RST_MAX_FRAME_LEN);
		queue_traffic(PHASE_BUDGET);
		wait_drained();

		repeat (10) @(posedge clk);
		$display("Sent %0d link beats under %0d register settings and three idle schedules.",
			bytes_accepted, settings_used);
		$display("Checked %0d result beats: %0d payload, %0d frame closes, %0d restarts.",
			result_beats, data_beats, frames_closed, restarts);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
				expected_results.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
